// ===== rtl/u8u16_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by every module in rtl/.
package u8u16_pkg;

   localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
   localparam logic [15:0] SUR_HI     = 16'hD800;
   localparam logic [15:0] SUR_LO     = 16'hDC00;
   localparam logic [20:0] SUPP_BASE  = 21'h010000;
   localparam logic [20:0] MAX_CP     = 21'h10FFFF;

   // sequence lengths; LEN_NONE marks a byte that cannot lead
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_1    = 3'd1;
   localparam logic [2:0] LEN_2    = 3'd2;
   localparam logic [2:0] LEN_3    = 3'd3;
   localparam logic [2:0] LEN_4    = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
      logic        string_done;
   } rsp_type;

   // up to three code units produced by one request, unit[0] goes out first
   typedef struct packed {
      logic [1:0]       count;
      logic             eos;
      logic [2:0][15:0] unit;
   } unit_set_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)             len = LEN_1;
      else if (b[7:5] == 3'b110)    len = LEN_2;
      else if (b[7:4] == 4'b1110)   len = LEN_3;
      else if (b[7:3] == 5'b11110)  len = LEN_4;
      else                          len = LEN_NONE;
      return len;
   endfunction

   // a lone byte at end of string: ASCII passes, anything else is replaced
   function automatic logic [15:0] single_unit(input logic [7:0] b);
      logic [15:0] u;
      u = b[7] ? REPL_UNIT : {8'h00, b};
      return u;
   endfunction

endpackage

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: request register, decoder and
// result register. Depends on u8u16_pkg, u8u16_decode and u8u16_outq.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    u8u16_pkg::req_type  (in_byte, end_of_string)
//   rsp      out  rsp_valid/stall    u8u16_pkg::rsp_type  (code_unit, last_unit,
//                                                          string_done)
//
// One request per cycle while each request yields at most one unit and rsp_stall
// is low; a request yielding k units (k up to 3) holds the result register until
// its last unit is taken. Each request passes the request register, then the
// result register. Bytes that only extend a sequence yield no unit.
// Synchronous reset clears the pending sequence and both valid flags.
// rsp_stall holds the current unit; req_stall rises only while the request
// register is full and the result register cannot take its units.
module utf8_to_utf16_transcoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  u8u16_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output u8u16_pkg::rsp_type  rsp_data
);

   logic                    in_valid_ff, in_valid_in;
   u8u16_pkg::req_type      in_req_ff;
   logic                    accept;
   logic                    advance;
   logic                    res_free;
   u8u16_pkg::unit_set_type units;

   always_comb begin
      req_stall   = in_valid_ff && !res_free;
      accept      = req_valid && !req_stall;
      advance     = in_valid_ff && res_free;
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_data;
      end
   end

   u8u16_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_req_ff.in_byte),
      .eos     (in_req_ff.end_of_string),
      .units   (units)
   );

   u8u16_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .units     (units),
      .free      (res_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty request register");

endmodule

// ===== rtl/u8u16_decode.sv =====
// Sequence buffer and decoder: holds the pending lead/continuation bytes and
// turns each request into a set of UTF-16 units. Depends on u8u16_pkg.
module u8u16_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              in_byte,
   input  logic                    eos,
   output u8u16_pkg::unit_set_type units
);

   logic [7:0]  pend_ff [3];
   logic [1:0]  count_ff, count_in;
   logic [2:0]  len_ff, len_in;
   logic        buffer_byte;

   logic [2:0]  len;
   logic        complete;
   logic [20:0] cp;
   logic [20:0] supp;
   logic [1:0]  full_count;
   logic [15:0] full_u0, full_u1;
   logic [15:0] pair_unit;

   always_comb begin
      len = (count_ff == 2'd0) ? u8u16_pkg::lead_len(in_byte) : len_ff;
      complete = (count_ff == 2'd0) ? (len == u8u16_pkg::LEN_1)
                                    : ({1'b0, count_ff} + 3'd1 == len);

      case (len)
         u8u16_pkg::LEN_2: cp = {10'h0, pend_ff[0][4:0], in_byte[5:0]};
         u8u16_pkg::LEN_3: cp = {5'h0, pend_ff[0][3:0], pend_ff[1][5:0], in_byte[5:0]};
         u8u16_pkg::LEN_4: cp = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0],
                                 in_byte[5:0]};
         default:          cp = {13'h0, in_byte};
      endcase

      supp = cp - u8u16_pkg::SUPP_BASE;
      if (cp[20:16] == 5'h0) begin
         full_count = 2'd1;
         full_u0    = cp[15:0];
         full_u1    = u8u16_pkg::REPL_UNIT;
      end else if (cp <= u8u16_pkg::MAX_CP) begin
         full_count = 2'd2;
         full_u0    = u8u16_pkg::SUR_HI | {6'h0, supp[19:10]};
         full_u1    = u8u16_pkg::SUR_LO | {6'h0, supp[9:0]};
      end else begin
         full_count = 2'd1;
         full_u0    = u8u16_pkg::REPL_UNIT;
         full_u1    = u8u16_pkg::REPL_UNIT;
      end

      // two-byte sequence starting at the second buffered byte
      pair_unit = {5'h0, pend_ff[1][4:0], in_byte[5:0]};

      units.eos   = eos;
      units.count = 2'd0;
      units.unit  = {3{u8u16_pkg::REPL_UNIT}};
      buffer_byte = 1'b0;

      if (!eos) begin
         if (count_ff == 2'd0 && len == u8u16_pkg::LEN_NONE) begin
            units.count = 2'd1;
         end else if (complete) begin
            units.count   = full_count;
            units.unit[0] = full_u0;
            units.unit[1] = full_u1;
         end else begin
            buffer_byte = 1'b1;
         end
      end else if (complete) begin
         units.count   = full_count;
         units.unit[0] = full_u0;
         units.unit[1] = full_u1;
      end else begin
         // truncated sequence: lead is replaced, the rest is read again as leads
         case (count_ff)
            2'd0: begin
               units.count   = 2'd1;
               units.unit[0] = u8u16_pkg::single_unit(in_byte);
            end
            2'd1: begin
               units.count   = 2'd2;
               units.unit[1] = u8u16_pkg::single_unit(in_byte);
            end
            default: begin
               if (u8u16_pkg::lead_len(pend_ff[1]) == u8u16_pkg::LEN_2) begin
                  units.count   = 2'd2;
                  units.unit[1] = pair_unit;
               end else begin
                  units.count   = 2'd3;
                  units.unit[1] = u8u16_pkg::single_unit(pend_ff[1]);
                  units.unit[2] = u8u16_pkg::single_unit(in_byte);
               end
            end
         endcase
      end

      count_in = count_ff;
      len_in   = len_ff;
      if (step) begin
         if (buffer_byte) begin
            count_in = count_ff + 2'd1;
            len_in   = len;
         end else begin
            count_in = 2'd0;
            len_in   = u8u16_pkg::LEN_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         len_ff   <= u8u16_pkg::LEN_NONE;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && buffer_byte) begin
         pend_ff[count_ff] <= in_byte;
      end
   end

   // a pending sequence is always shorter than its lead's length
   a_pending_short: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd0 |-> ({1'b0, count_ff} < len_ff && len_ff >= u8u16_pkg::LEN_2))
      else $error("pending count reached sequence length");

endmodule

// ===== rtl/u8u16_outq.sv =====
// Result register: holds the units of one request and hands them out one per
// cycle under rsp_stall. Depends on u8u16_pkg.
module u8u16_outq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  u8u16_pkg::unit_set_type units,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output u8u16_pkg::rsp_type      rsp_data
);

   logic             valid_ff, valid_in;
   logic [1:0]       left_ff, left_in;
   logic             eos_ff, eos_in;
   logic [2:0][15:0] unit_ff, unit_in;
   logic             take;
   logic             last;

   always_comb begin
      take = valid_ff && !rsp_stall;
      last = (left_ff == 2'd1);
      free = !valid_ff || (take && last);

      valid_in = valid_ff;
      left_in  = left_ff;
      eos_in   = eos_ff;
      unit_in  = unit_ff;

      if (take) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            left_in = left_ff - 2'd1;
            unit_in = {unit_ff[2], unit_ff[2], unit_ff[1]};
         end
      end
      if (load && units.count != 2'd0) begin
         valid_in = 1'b1;
         left_in  = units.count;
         eos_in   = units.eos;
         unit_in  = units.unit;
      end

      rsp_valid             = valid_ff;
      rsp_data.code_unit    = unit_ff[0];
      rsp_data.last_unit    = last;
      rsp_data.string_done  = last && eos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      eos_ff  <= eos_in;
      unit_ff <= unit_in;
   end

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> left_ff != 2'd0)
      else $error("result held with no units left");

   a_more_units: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_stall && !last) |=> valid_ff)
      else $error("result dropped before its last unit");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (load && units.count != 2'd0) |-> free)
      else $error("result overwritten while still held");

endmodule
